// File: design/free_map_allocator_best_worst_fit_defines.svh
// assertion macros for the free map allocator
`ifndef FREE_MAP_ALLOCATOR_BEST_WORST_FIT_DEFINES_SVH
`define FREE_MAP_ALLOCATOR_BEST_WORST_FIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define FMA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define FMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fma_pkg.sv
`default_nettype none
package fma_pkg;
  localparam int unsigned TableDepth = 128;
  localparam int unsigned IdxBits = $clog2(TableDepth);
  localparam int unsigned CntBits = $clog2(TableDepth + 1);
  localparam int unsigned AddrBits = 32;
  localparam int unsigned LenBits = 32;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusNoFit = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;
  localparam logic [1:0] StatusOverflow = 2'd3;

  localparam logic KindAlloc = 1'b0;

  localparam logic [1:0] RegFitMode = 2'd0;
  localparam logic [1:0] RegBase = 2'd1;
  localparam logic [1:0] RegLength = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_t;

  // memory entry: start and length
  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [LenBits-1:0] length;
  } hole_t;
endpackage
`default_nettype wire

// File: design/free_map_allocator_best_worst_fit.sv
// done follows the scan over the N current holes (N at most 128), the decide and update
// states and, when a hole is removed or inserted, a shift that moves entries one by one
// (at most N+1 entries); one request at a time, the next start is taken in the done cycle
// the scan reads one table entry per cycle from the hole table memory
// result is shown for one cycle on done; the receiver cannot stall
// reset or any configuration write rebuilds the table from the region registers
`default_nettype none
`include "free_map_allocator_best_worst_fit_defines.svh"
module free_map_allocator_best_worst_fit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind,
  input  wire logic [31:0] request_address,
  input  wire logic [31:0] request_size,
  output logic             done,
  output logic [31:0]      granted_address,
  output logic [1:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int unsigned IB = fma_pkg::IdxBits;
  localparam int unsigned CB = fma_pkg::CntBits;

  fma_pkg::state_t state, state_next;

  logic fit_mode;
  logic [31:0] region_base, region_length;
  logic [31:0] cfg_base_eff, cfg_len_eff;
  logic [CB-1:0] count;
  logic req_kind;
  logic [31:0] req_addr, req_size;
  logic [CB-1:0] ptr;
  logic found;
  logic [IB-1:0] sel;
  fma_pkg::hole_t sel_h, prev_h, next_h;
  logic [CB-1:0] pos;
  logic pos_found;
  logic [1:0] res_status;
  logic [31:0] res_addr;
  logic need_shift, shift_up;
  logic [CB-1:0] shift_ptr, shift_end;
  fma_pkg::hole_t ins_h;

  logic we;
  logic [IB-1:0] waddr, raddr;
  fma_pkg::hole_t wdata, rdata;

  fma_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // a request transaction has priority over a configuration write
  assign busy = (state != fma_pkg::ST_IDLE);
  assign cfg_ready = (state == fma_pkg::ST_IDLE) && !start;

  // scan index trails the read address by one entry to match the registered read
  logic [CB-1:0] rd_idx;
  logic rd_ok;
  assign rd_ok = (rd_idx < count);

  // free-side comparisons on the current neighbor pair
  logic prev_ok, next_ok;
  logic [32:0] nl;
  logic has_prev;
  assign has_prev = (pos != '0);
  assign prev_ok = has_prev && ((req_addr - prev_h.start) == prev_h.length);
  assign next_ok = (pos < count) && ((next_h.start - req_addr) == req_size);
  always_comb begin
    nl = {1'b0, req_size};
    if (prev_ok) nl = nl + {1'b0, prev_h.length};
    if (next_ok) nl = nl + {1'b0, next_h.length};
  end

  // initial region after a configuration write, cut to end at the top address
  always_comb begin
    cfg_base_eff = (cfg_index == fma_pkg::RegBase) ? cfg_data : region_base;
    cfg_len_eff = (cfg_index == fma_pkg::RegLength) ? cfg_data : region_length;
    if (cfg_len_eff != '0 && (cfg_len_eff - 1'b1) > (32'hFFFF_FFFF - cfg_base_eff)) begin
      cfg_len_eff = 32'hFFFF_FFFF - cfg_base_eff + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fma_pkg::ST_IDLE:
        if (start) state_next = fma_pkg::ST_SCAN_RD;
      fma_pkg::ST_SCAN_RD: state_next = fma_pkg::ST_SCAN;
      fma_pkg::ST_SCAN: if (!rd_ok) state_next = fma_pkg::ST_DECIDE;
      fma_pkg::ST_DECIDE: state_next = fma_pkg::ST_UPDATE;
      fma_pkg::ST_UPDATE:
        state_next = need_shift ? fma_pkg::ST_SHIFT_RD : fma_pkg::ST_DONE;
      fma_pkg::ST_SHIFT_RD: state_next = fma_pkg::ST_SHIFT_WR;
      fma_pkg::ST_SHIFT_WR:
        state_next = (shift_ptr == shift_end) ? fma_pkg::ST_DONE : fma_pkg::ST_SHIFT_RD;
      fma_pkg::ST_DONE: state_next = fma_pkg::ST_IDLE;
      default: state_next = fma_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = ins_h;
    raddr = ptr[IB-1:0];
    unique case (state)
      fma_pkg::ST_IDLE: begin
        we = cfg_valid && !start;
        waddr = '0;
        wdata.start = cfg_base_eff;
        wdata.length = cfg_len_eff;
      end
      fma_pkg::ST_SHIFT_RD:
        raddr = shift_up ? IB'(shift_ptr - 1'b1) : IB'(shift_ptr + 1'b1);
      fma_pkg::ST_SHIFT_WR: begin
        we = 1'b1;
        waddr = shift_ptr[IB-1:0];
        wdata = (shift_up && shift_ptr == shift_end) ? ins_h : rdata;
      end
      fma_pkg::ST_UPDATE: begin
        // an insert writes its entry at the end of the upward shift
        we = (res_status == fma_pkg::StatusOk) && !(need_shift && shift_up) &&
             (req_size != '0);
        waddr = sel;
        wdata = ins_h;
      end
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fma_pkg::ST_IDLE;
      fit_mode <= 1'b0;
      region_base <= '0;
      region_length <= '0;
      count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      unique case (state)
        fma_pkg::ST_IDLE: begin
          if (start) begin
            req_kind <= kind;
            req_addr <= request_address;
            req_size <= request_size;
            ptr <= '0;
            rd_idx <= '0;
            found <= 1'b0;
            pos <= '0;
            pos_found <= 1'b0;
            prev_h <= '0;
            next_h <= '0;
          end else if (cfg_valid) begin
            if (cfg_index == fma_pkg::RegFitMode) fit_mode <= cfg_data[0];
            if (cfg_index == fma_pkg::RegBase) begin
              region_base <= cfg_data;
              count <= CB'(region_length != '0);
            end
            if (cfg_index == fma_pkg::RegLength) begin
              region_length <= cfg_data;
              count <= CB'(cfg_data != '0);
            end
            if (cfg_index == fma_pkg::RegFitMode) count <= CB'(region_length != '0);
          end
        end
        fma_pkg::ST_SCAN_RD: ptr <= ptr + 1'b1;
        fma_pkg::ST_SCAN: begin
          ptr <= ptr + 1'b1;
          rd_idx <= rd_idx + 1'b1;
          if (rd_ok) begin
            if (req_kind == fma_pkg::KindAlloc) begin
              if (rdata.length >= req_size) begin
                if (!found) begin
                  found <= 1'b1; sel <= rd_idx[IB-1:0]; sel_h <= rdata;
                end else if (fit_mode ? (rdata.length > sel_h.length)
                                      : (rdata.length < sel_h.length)) begin
                  sel <= rd_idx[IB-1:0]; sel_h <= rdata;
                end
              end
            end else if (!pos_found) begin
              if (rdata.start <= req_addr) begin
                prev_h <= rdata; pos <= rd_idx + 1'b1;
              end else begin
                next_h <= rdata; pos_found <= 1'b1;
              end
            end
          end
        end
        fma_pkg::ST_DECIDE: begin
          need_shift <= 1'b0;
          res_addr <= '0;
          res_status <= fma_pkg::StatusOk;
          if (req_kind == fma_pkg::KindAlloc) begin
            if (!found) res_status <= fma_pkg::StatusNoFit;
            else begin
              res_addr <= sel_h.start;
              ins_h.start <= sel_h.start + req_size;
              ins_h.length <= sel_h.length - req_size;
              if (req_size != '0 && sel_h.length == req_size) begin
                need_shift <= (CB'(sel) + 1'b1) < count;
                shift_up <= 1'b0;
                shift_ptr <= CB'(sel);
                shift_end <= count - 2'd2;
              end
            end
          end else if (req_size == '0) begin
            res_status <= fma_pkg::StatusOk;
          end else if ((req_size - 1'b1) > (32'hFFFF_FFFF - req_addr)) begin
            res_status <= fma_pkg::StatusOverflow;
          end else if (prev_ok || next_ok) begin
            if (nl[32]) res_status <= fma_pkg::StatusOverflow;
            else if (prev_ok) begin
              sel <= IB'(pos - 1'b1);
              ins_h.start <= prev_h.start;
              ins_h.length <= nl[31:0];
              if (next_ok) begin
                need_shift <= (pos + 1'b1) < count;
                shift_up <= 1'b0;
                shift_ptr <= pos;
                shift_end <= count - 2'd2;
              end
            end else begin
              sel <= pos[IB-1:0];
              ins_h.start <= req_addr;
              ins_h.length <= nl[31:0];
            end
          end else if (count >= CB'(fma_pkg::TableDepth)) begin
            res_status <= fma_pkg::StatusFull;
          end else begin
            ins_h.start <= req_addr;
            ins_h.length <= req_size;
            sel <= pos[IB-1:0];
            need_shift <= 1'b1;
            shift_up <= 1'b1;
            shift_ptr <= count;
            shift_end <= pos;
          end
        end
        fma_pkg::ST_UPDATE: begin
          if (res_status == fma_pkg::StatusOk && req_size != '0) begin
            if (req_kind == fma_pkg::KindAlloc) begin
              if (sel_h.length == req_size) count <= count - 1'b1;
            end else if (prev_ok && next_ok) count <= count - 1'b1;
            else if (!prev_ok && !next_ok) count <= count + 1'b1;
          end
        end
        fma_pkg::ST_SHIFT_WR:
          shift_ptr <= shift_up ? shift_ptr - 1'b1 : shift_ptr + 1'b1;
        fma_pkg::ST_DONE: begin
          done <= 1'b1;
          granted_address <= res_addr;
          status <= res_status;
        end
        default: ;
      endcase
    end
  end

  `FMA_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
  `FMA_ASSERT_IMP(a_count_bound, 1'b1, count <= fma_pkg::TableDepth, "hole count overflow")
  `FMA_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "start not taken")
endmodule
`default_nettype wire

// File: design/fma_ram.sv
`default_nettype none
module fma_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [fma_pkg::IdxBits-1:0] waddr,
  input  wire fma_pkg::hole_t            wdata,
  input  wire logic [fma_pkg::IdxBits-1:0] raddr,
  output fma_pkg::hole_t                 rdata
);
  fma_pkg::hole_t mem [fma_pkg::TableDepth];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
